[hdl/round_robin_run_queue_top_defines.svh]
// Assertion macros for the round-robin run queue.
// Included by the modules that check their own logic; needs no other file.
`ifndef ROUND_ROBIN_RUN_QUEUE_TOP_DEFINES_SVH
`define ROUND_ROBIN_RUN_QUEUE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define RRQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
`define RRQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define RRQ_ASSERT(lbl, prop, msg)
`define RRQ_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

[hdl/rrq_pkg.sv]
// Types and constants shared by the round-robin run queue.
// Depends on nothing.
package rrq_pkg;
    localparam int NUM_TASKS = 16;
    localparam int TASK_W    = 4;
    localparam int SLOT_W    = $clog2(NUM_TASKS);
    localparam int CNT_W     = 5;
    localparam int SLICE_W   = 8;
    localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd1;

    typedef enum logic [1:0] {
        ACT_ENQ  = 2'd0,
        ACT_DEQ  = 2'd1,
        ACT_TICK = 2'd2
    } t_action;

    typedef struct packed {
        logic [1:0]        action;
        logic [TASK_W-1:0] task_id;
    } t_rrq_cmd;

    typedef struct packed {
        logic              head_valid;
        logic [TASK_W-1:0] head_task;
        logic              resched;
        logic [CNT_W-1:0]  queued_count;
    } t_rrq_res;
endpackage

[hdl/round_robin_run_queue_top.sv]
// Round-robin run queue with per-task time slices, top level.
// Depends on rrq_pkg and round_robin_run_queue_top_defines.svh.
//
//  channel   signals                          transfer when
//  command   start, busy, i_cmd               start && !busy
//  result    o_res_strobe, o_res              o_res_strobe (one cycle, no stall)
//  config    i_cfg_valid, o_cfg_ready, i_cfg  i_cfg_valid && o_cfg_ready
//
// A command is registered in r_cmd on transfer; its result is registered in r_res and
// transfers while o_res_strobe is high. A command can be taken every cycle.
// The queue is a row of slot registers kept in order, so each command is one pass of
// compare and shift.
// Synchronous active-low reset empties the queue, clears all slices and sets
// the slice length to one. busy stays low and results cannot be held off.
`include "round_robin_run_queue_top_defines.svh"

module round_robin_run_queue_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  rrq_pkg::t_rrq_cmd i_cmd,
    output logic            o_res_strobe,
    output rrq_pkg::t_rrq_res o_res,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [rrq_pkg::SLICE_W-1:0] i_cfg
);
    import rrq_pkg::*;

    logic                     r_in_valid;
    t_rrq_cmd                 r_cmd;
    logic                     r_out_valid;
    t_rrq_res                 r_res;
    t_rrq_res                 n_res;
    logic [SLICE_W-1:0]       r_slice_len;
    logic [TASK_W-1:0]        r_slot   [NUM_TASKS];
    logic [TASK_W-1:0]        n_slot   [NUM_TASKS];
    logic [SLICE_W-1:0]       r_slice  [NUM_TASKS];
    logic [SLICE_W-1:0]       n_slice  [NUM_TASKS];
    logic [NUM_TASKS-1:0]     r_queued;
    logic [NUM_TASKS-1:0]     n_queued;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;

    logic                     cmd_go;
    logic                     tid_ok;
    logic                     cur_queued;
    logic [SLICE_W-1:0]       cur_slice;
    logic [NUM_TASKS-1:0]     match;
    logic [SLOT_W-1:0]        pos;
    logic                     do_remove;
    logic                     do_append;
    logic [CNT_W-1:0]         wr_idx;
    logic [CNT_W-1:0]         others;
    logic                     resched;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign cmd_go      = start && !busy;

    assign tid_ok     = ({1'b0, r_cmd.task_id} < (TASK_W + 1)'(NUM_TASKS));
    assign cur_queued = r_queued[r_cmd.task_id];
    assign cur_slice  = r_slice[r_cmd.task_id];
    assign others     = r_count - CNT_W'(cur_queued);

    // Locate the task among the occupied slots; at most one slot matches.
    always_comb begin
        pos = '0;
        for (int i = 0; i < NUM_TASKS; i++) begin
            match[i] = (r_slot[i] == r_cmd.task_id) && (CNT_W'(i) < r_count);
            if (match[i]) begin
                pos = pos | SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_queued  = r_queued;
        n_slice   = r_slice;
        n_count   = r_count;
        do_remove = 1'b0;
        do_append = 1'b0;
        wr_idx    = r_count;
        resched   = 1'b0;
        if (r_in_valid && tid_ok) begin
            case (r_cmd.action)
                ACT_ENQ: begin
                    if (!cur_queued) begin
                        do_append                = 1'b1;
                        n_queued[r_cmd.task_id]  = 1'b1;
                        n_slice[r_cmd.task_id]   = r_slice_len;
                        n_count                  = r_count + CNT_W'(1);
                    end
                end
                ACT_DEQ: begin
                    if (cur_queued) begin
                        do_remove               = 1'b1;
                        n_queued[r_cmd.task_id] = 1'b0;
                        n_count                 = r_count - CNT_W'(1);
                    end
                end
                ACT_TICK: begin
                    if (cur_slice > SLICE_W'(1)) begin
                        n_slice[r_cmd.task_id] = cur_slice - SLICE_W'(1);
                    end else begin
                        n_slice[r_cmd.task_id] = r_slice_len;
                        if (others != '0) begin
                            resched = 1'b1;
                            // Rotation: take the task out and put it back last.
                            if (cur_queued) begin
                                do_remove = 1'b1;
                                do_append = 1'b1;
                                wr_idx    = r_count - CNT_W'(1);
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Removal closes the gap by shifting later slots down; append then
    // writes the task into the first free slot.
    always_comb begin
        for (int i = 0; i < NUM_TASKS; i++) begin
            n_slot[i] = r_slot[i];
            if (do_remove && (SLOT_W'(i) >= pos) && (i < NUM_TASKS - 1)) begin
                n_slot[i] = r_slot[(i + 1) % NUM_TASKS];
            end
            if (do_append && (CNT_W'(i) == wr_idx)) begin
                n_slot[i] = r_cmd.task_id;
            end
        end
    end

    always_comb begin
        n_res.head_valid   = (n_count != '0);
        n_res.head_task    = (n_count != '0) ? n_slot[0] : '0;
        n_res.resched      = resched;
        n_res.queued_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_slice_len <= SLICE_RESET;
            r_queued    <= '0;
            r_count     <= '0;
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_slice[i] <= '0;
            end
        end else begin
            r_in_valid  <= cmd_go;
            r_out_valid <= r_in_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_slice_len <= i_cfg;
            end
            r_queued <= n_queued;
            r_count  <= n_count;
            r_slice  <= n_slice;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_go) begin
            r_cmd <= i_cmd;
        end
        r_slot <= n_slot;
        r_res  <= n_res;
    end

    assign o_res_strobe = r_out_valid;
    assign o_res        = r_res;

    `RRQ_ASSERT(a_count_bound, r_count <= CNT_W'(NUM_TASKS), "queue count above task count")
    `RRQ_ASSERT(a_count_flags, $countones(r_queued) == 32'(r_count), "count and flags differ")
    `RRQ_ASSERT_IMP(a_head_queued, r_count != '0, r_queued[r_slot[0]], "idle task at head")
    `RRQ_ASSERT_IMP(a_res_timing, r_in_valid, ##1 o_res_strobe, "result strobe missing")
endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the round-robin run queue top level.
// Depends on rrq_pkg and the RTL; predicts each status item in-house unless a directed row types it.
module tb_top;
    import rrq_pkg::*;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam bit         ROW_CMD     = 1'b0;
    localparam bit         ROW_CFG     = 1'b1;
    localparam int         STALL_LIMIT = 2000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         NUM_ROWS    = 25;
    localparam int         NUM_PHASES  = 6;
    localparam int         PHASE_ITEMS = 64;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_rrq_cmd i_cmd;
    logic o_res_strobe;
    t_rrq_res o_res;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [SLICE_W-1:0] i_cfg;

    round_robin_run_queue_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg        (i_cfg)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state: the run order as a plain queue of task ids.
    logic [TASK_W-1:0]  run_order[$];
    bit                 task_queued [NUM_TASKS];
    logic [SLICE_W-1:0] slice_left  [NUM_TASKS];
    logic [SLICE_W-1:0] slice_len;

    t_rrq_res pending_status[$];
    int       mismatch_count = 0;
    int       idle_pct = 0;
    int       stall_cycles = 0;

    typedef struct packed {
        bit                 kind;
        logic [1:0]         action;
        logic [TASK_W-1:0]  task_id;
        logic [SLICE_W-1:0] cfg;
        bit                 typed;
        logic               exp_valid;
        logic [TASK_W-1:0]  exp_head;
        logic               exp_resched;
        logic [CNT_W-1:0]   exp_count;
    } t_dir_row;

    t_dir_row dir_rows [NUM_ROWS] = '{
        '{ROW_CMD, ACT_TICK,   4'd5,  8'd0,   1'b1, 1'b0, 4'd0, 1'b0, 5'd0},
        '{ROW_CMD, ACT_DEQ,    4'd3,  8'd0,   1'b1, 1'b0, 4'd0, 1'b0, 5'd0},
        '{ROW_CMD, ACT_UNUSED, 4'd15, 8'd0,   1'b1, 1'b0, 4'd0, 1'b0, 5'd0},
        '{ROW_CMD, ACT_ENQ,    4'd0,  8'd0,   1'b1, 1'b1, 4'd0, 1'b0, 5'd1},
        '{ROW_CMD, ACT_ENQ,    4'd0,  8'd0,   1'b1, 1'b1, 4'd0, 1'b0, 5'd1},
        '{ROW_CMD, ACT_ENQ,    4'd15, 8'd0,   1'b1, 1'b1, 4'd0, 1'b0, 5'd2},
        '{ROW_CMD, ACT_ENQ,    4'd7,  8'd0,   1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{ROW_CMD, ACT_TICK,   4'd0,  8'd0,   1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{ROW_CMD, ACT_TICK,   4'd9,  8'd0,   1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{ROW_CMD, ACT_TICK,   4'd0,  8'd0,   1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{ROW_CMD, ACT_DEQ,    4'd15, 8'd0,   1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{ROW_CMD, ACT_DEQ,    4'd0,  8'd0,   1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{ROW_CMD, ACT_DEQ,    4'd7,  8'd0,   1'b1, 1'b0, 4'd0, 1'b0, 5'd0},
        '{ROW_CFG, ACT_ENQ,    4'd0,  8'd0,   1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{ROW_CMD, ACT_ENQ,    4'd4,  8'd0,   1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{ROW_CMD, ACT_TICK,   4'd4,  8'd0,   1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{ROW_CMD, ACT_ENQ,    4'd10, 8'd0,   1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{ROW_CMD, ACT_TICK,   4'd4,  8'd0,   1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{ROW_CFG, ACT_ENQ,    4'd0,  8'd255, 1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{ROW_CMD, ACT_ENQ,    4'd12, 8'd0,   1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{ROW_CMD, ACT_TICK,   4'd12, 8'd0,   1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{ROW_CMD, ACT_UNUSED, 4'd12, 8'd0,   1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{ROW_CMD, ACT_DEQ,    4'd4,  8'd0,   1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{ROW_CFG, ACT_ENQ,    4'd0,  8'd2,   1'b0, 1'b0, 4'd0, 1'b0, 5'd0},
        '{ROW_CMD, ACT_TICK,   4'd10, 8'd0,   1'b0, 1'b0, 4'd0, 1'b0, 5'd0}
    };

    int unsigned phase_slice [NUM_PHASES] = '{2, 255, 0, 3, 1, 5};
    int unsigned phase_idle  [NUM_PHASES] = '{36, 36, 48, 48, 0, 0};

    function automatic void drop_from_order(logic [TASK_W-1:0] tid);
        for (int i = 0; i < run_order.size(); i++) begin
            if (run_order[i] == tid) begin
                run_order.delete(i);
                break;
            end
        end
    endfunction

    function automatic t_rrq_res predict_queue_step(t_rrq_cmd cmd);
        t_rrq_res          res;
        logic [TASK_W-1:0] tid;
        int                others;
        tid = cmd.task_id;
        res.resched = 1'b0;
        case (cmd.action)
            ACT_ENQ: begin
                if (!task_queued[tid]) begin
                    run_order.push_back(tid);
                    task_queued[tid] = 1'b1;
                    slice_left[tid] = slice_len;
                end
            end
            ACT_DEQ: begin
                if (task_queued[tid]) begin
                    drop_from_order(tid);
                    task_queued[tid] = 1'b0;
                end
            end
            ACT_TICK: begin
                // A slice of zero or one expires; an unqueued task is never moved.
                if (slice_left[tid] > 1) begin
                    slice_left[tid] = slice_left[tid] - 1'b1;
                end else begin
                    others = run_order.size() - (task_queued[tid] ? 1 : 0);
                    slice_left[tid] = slice_len;
                    if (others > 0) begin
                        if (task_queued[tid] && run_order[$] != tid) begin
                            drop_from_order(tid);
                            run_order.push_back(tid);
                        end
                        res.resched = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.head_valid   = (run_order.size() > 0);
        res.head_task    = (run_order.size() > 0) ? run_order[0] : '0;
        res.queued_count = CNT_W'(run_order.size());
        return res;
    endfunction

    function automatic t_rrq_cmd pick_command();
        t_rrq_cmd    cmd;
        int unsigned roll;
        roll = $urandom_range(99);
        cmd.task_id = TASK_W'($urandom_range(NUM_TASKS - 1));
        if (roll < 35) begin
            cmd.action = ACT_ENQ;
        end else if (roll < 55) begin
            cmd.action = ACT_DEQ;
            if (run_order.size() > 0 && $urandom_range(99) < 70)
                cmd.task_id = run_order[$urandom_range(run_order.size() - 1)];
        end else if (roll < 95) begin
            // Mostly tick the task at the head, as a running task would be.
            cmd.action = ACT_TICK;
            if (run_order.size() > 0 && $urandom_range(99) < 70)
                cmd.task_id = run_order[0];
        end else begin
            cmd.action = ACT_UNUSED;
        end
        return cmd;
    endfunction

    task automatic send_command(t_rrq_cmd cmd, bit typed, t_rrq_res typed_res);
        t_rrq_res predicted;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        predicted = predict_queue_step(cmd);
        pending_status.push_back(typed ? typed_res : predicted);
    endtask

    // Only written with no status pending, so no command sees a stale length.
    task automatic write_slice_length(logic [SLICE_W-1:0] value);
        start <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg <= value;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready)
                break;
        end
        slice_len = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rrq_res want;
        if (i_rst_n && o_res_strobe) begin
            if (pending_status.size() == 0) begin
                $display("%0t: unexpected status transfer, expected none actual %h",
                         $time, o_res);
                mismatch_count++;
            end else begin
                want = pending_status.pop_front();
                check_field("head_valid", want.head_valid, o_res.head_valid);
                check_field("head_task", want.head_task, o_res.head_task);
                check_field("resched", want.resched, o_res.resched);
                check_field("queued_count", want.queued_count, o_res.queued_count);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_strobe || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("round_robin_run_queue_top verification failed");
            $finish;
        end
    end

    initial begin
        t_rrq_cmd cmd;
        t_rrq_res typed_res;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_cmd       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg       <= '0;
        foreach (task_queued[i]) begin
            task_queued[i] = 1'b0;
            slice_left[i] = '0;
        end
        slice_len = SLICE_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 36;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                write_slice_length(dir_rows[r].cfg);
            end else begin
                cmd.action   = dir_rows[r].action;
                cmd.task_id  = dir_rows[r].task_id;
                typed_res.head_valid   = dir_rows[r].exp_valid;
                typed_res.head_task    = dir_rows[r].exp_head;
                typed_res.resched      = dir_rows[r].exp_resched;
                typed_res.queued_count = dir_rows[r].exp_count;
                send_command(cmd, dir_rows[r].typed, typed_res);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_slice_length(SLICE_W'(phase_slice[p]));
            idle_pct = phase_idle[p];
            repeat (PHASE_ITEMS) begin
                cmd = pick_command();
                send_command(cmd, 1'b0, '0);
            end
        end

        start <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("round_robin_run_queue_top verification clean");
        else
            $display("round_robin_run_queue_top verification failed");
        $finish;
    end
endmodule

[sim.f]
+incdir+hdl
hdl/rrq_pkg.sv
hdl/round_robin_run_queue_top.sv
tb/tb_top.sv
